// File: hw/rtl/insp_pkg.sv
package insp_pkg;

  localparam int DIM_W = 10;
  localparam int POS_W = 21;
  localparam int ROW_W = 18;
  localparam int OUT_W = 18;
  localparam int CFG_IDX_W = 8;

  localparam int DEF_MAX_WIDTH = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MARGIN = 10;
  localparam int RESET_DIM = 512;

  localparam logic [7:0] THRESHOLD = 8'd230;
  localparam logic [7:0] FULL = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel;
    logic       frame_start;
  } insp_in_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] x_num;
    logic [OUT_W-1:0] y_num;
    logic [9:0]       dark_x4;
    logic [OUT_W-1:0] pixel_index;
  } insp_out_t;

  typedef struct packed {
    logic       fetch;
    logic       start;
    logic [7:0] pixel;
  } insp_cmd_t;

endpackage

// File: hw/rtl/invert_normalize_subpixel_points.sv
// Dark-point detector. Push load requests (command 0) to stream an 8-bit
// grayscale frame into the internal frame store in raster order, with
// frame_start set on the first pixel; push a fetch request (command 1) to
// receive the next detected point, or found = 0 once the frame is exhausted.
// Loads produce no result. A frame streams at one pixel per clock while no
// fetch or divide is in progress; after any configuration write, the first
// load without frame_start waits while the serial divider recomputes the
// write column. A fetch locates the scan position in its row with the
// divider, scans pixel by pixel, and for a candidate pixel reads each window
// value, rescaling values that need it in the divider; the single shared
// one-bit-per-cycle divider serves all of these. A two-entry request queue
// separates intake from execution, and a result register holds a finished
// result until it is popped; a fetch does not start while an earlier result
// is still waiting there. Frame size must be written through the configuration
// channel only while the block is idle; the block itself does not enforce this.
module invert_normalize_subpixel_points #(
  parameter int MAX_WIDTH = insp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = insp_pkg::DEF_MAX_HEIGHT,
  parameter int MARGIN = insp_pkg::DEF_MARGIN
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  insp_pkg::insp_in_t             request,
  output logic                           empty,
  input  logic                           pop,
  output insp_pkg::insp_out_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [insp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [insp_pkg::DIM_W-1:0]     cfg_data
);
  import insp_pkg::*;

  // Frame size registers; the back end clamps them to the legal range.
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             cfg_we;

  logic       cmd_valid;
  insp_cmd_t  cmd;
  logic       cmd_pop;
  logic       res_valid;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;
  assign empty = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= DIM_W'(RESET_DIM);
      frame_height <= DIM_W'(RESET_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end queues and decodes requests.
  insp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // The back end owns the frame store, the scan and the result register.
  insp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MARGIN     (MARGIN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .cfg_we     (cfg_we),
    .cfg_width  (frame_width),
    .cfg_height (frame_height),
    .res_valid  (res_valid),
    .res        (result),
    .res_pop    (pop)
  );

endmodule

// File: hw/rtl/insp_front.sv
module insp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  insp_pkg::insp_in_t request,
  output logic               cmd_valid,
  output insp_pkg::insp_cmd_t cmd,
  input  logic               cmd_pop
);
  import insp_pkg::*;

  // Two-entry queue of decoded requests.
  insp_cmd_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr].fetch <= (request.command == CMD_FETCH);
      entry[wr_ptr].start <= request.frame_start;
      entry[wr_ptr].pixel <= request.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: hw/rtl/insp_div.sv
module insp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [insp_pkg::POS_W-1:0] dividend,
  input  logic [insp_pkg::DIM_W:0]   divisor,
  output logic                       done,
  output logic [insp_pkg::POS_W-1:0] quot,
  output logic [insp_pkg::DIM_W:0]   rem
);
  import insp_pkg::*;

  // Restoring division, one quotient bit per cycle.
  localparam int CNT_W = $clog2(POS_W + 1);

  logic [DIM_W:0]   d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIM_W+1:0] trial;
  logic             fits;

  assign trial = {rem, quot[POS_W-1]};
  assign fits = (trial >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(POS_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      d <= divisor;
    end else if (busy) begin
      quot <= {quot[POS_W-2:0], fits};
      rem <= fits ? (DIM_W+1)'(trial - {1'b0, d}) : trial[DIM_W:0];
    end
  end

endmodule

// File: hw/rtl/insp_back.sv
module insp_back #(
  parameter int MAX_WIDTH = insp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = insp_pkg::DEF_MAX_HEIGHT,
  parameter int MARGIN = insp_pkg::DEF_MARGIN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  insp_pkg::insp_cmd_t        cmd,
  output logic                       cmd_pop,
  input  logic                       cfg_we,
  input  logic [insp_pkg::DIM_W-1:0] cfg_width,
  input  logic [insp_pkg::DIM_W-1:0] cfg_height,
  output logic                       res_valid,
  output insp_pkg::insp_out_t        res,
  input  logic                       res_pop
);
  import insp_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SA = $clog2(DEPTH);
  localparam int AW = (SA > POS_W) ? SA : POS_W;
  localparam int MIN_DIM = 2 * MARGIN + 2;
  localparam int RESET_W0 = (RESET_DIM < MIN_DIM) ? MIN_DIM : RESET_DIM;
  localparam int RESET_W = (RESET_W0 > MAX_WIDTH) ? MAX_WIDTH : RESET_W0;
  localparam int RESET_POS = MARGIN * RESET_W + MARGIN;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WDIV = 4'd1;
  localparam logic [3:0] S_SDIV = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_VAL  = 4'd6;
  localparam logic [3:0] S_RDIV = 4'd7;
  localparam logic [3:0] S_TEST = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (32'(v) < MIN_DIM) r = DIM_W'(MIN_DIM);
    if (32'(r) > maxv) r = DIM_W'(maxv);
    return r;
  endfunction

  function automatic logic is_inner(input logic [DIM_W-1:0] c, input logic [ROW_W-1:0] r,
                                    input logic [DIM_W-1:0] wd, input logic [DIM_W-1:0] ht);
    return (32'(c) >= MARGIN) && (32'(c) + MARGIN < 32'(wd)) &&
           (32'(r) >= MARGIN) && (32'(r) + MARGIN < 32'(ht));
  endfunction

  function automatic logic in_store(input logic [POS_W-1:0] a);
    return 32'(a) < DEPTH;
  endfunction

  logic [7:0]         store [DEPTH];
  logic [7:0]         rdata;
  logic               rd_en;
  logic [POS_W-1:0]   rd_addr;
  logic [AW-1:0]      rd_ext;
  logic [AW-1:0]      wr_ext;
  logic               wr_en;

  logic [3:0]         state;
  logic [DIM_W-1:0]   w;
  logic [DIM_W-1:0]   h;
  logic [2*DIM_W-1:0] end_pos;

  logic [17:0]        wa;
  logic [7:0]         maxv;
  logic               wsync;
  logic [DIM_W-1:0]   wcol;
  logic [ROW_W-1:0]   wrow;

  logic [POS_W-1:0]   pos;
  logic [DIM_W-1:0]   x;
  logic [ROW_W-1:0]   y;
  logic [1:0]         k;
  logic               beyond;
  logic               inner_kr;
  logic [7:0]         win [4];

  logic               div_start;
  logic [POS_W-1:0]   div_a;
  logic [DIM_W:0]     div_b;
  logic               div_done;
  logic [POS_W-1:0]   div_quot;
  logic [DIM_W:0]     div_rem;

  logic               load_go;
  logic [17:0]        ld_addr;
  logic [DIM_W-1:0]   ld_col;
  logic [ROW_W-1:0]   ld_row;
  logic [7:0]         ld_max;
  logic [7:0]         ld_inv;

  logic [DIM_W-1:0]   x1;
  logic [ROW_W-1:0]   y1;
  logic [POS_W-1:0]   addr_k;
  logic               inner_k;
  logic               pos_end;
  logic [7:0]         raw;
  logic [7:0]         inv;
  logic [15:0]        prod;
  logic               hit;
  logic [31:0]        xs;
  logic [31:0]        ys;
  logic [31:0]        dk;

  assign w = clamp(cfg_width, MAX_WIDTH);
  assign h = clamp(cfg_height, MAX_HEIGHT);

  always_ff @(posedge clk) begin
    end_pos <= w * h;
  end

  insp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Load path.
  assign load_go = (state == S_IDLE) && cmd_valid && !cmd.fetch && (cmd.start || wsync);
  assign ld_addr = cmd.start ? 18'd0 : wa;
  assign ld_col = cmd.start ? '0 : wcol;
  assign ld_row = cmd.start ? '0 : wrow;
  assign ld_max = cmd.start ? 8'd0 : maxv;
  assign ld_inv = ~cmd.pixel;
  assign wr_en = load_go && in_store(POS_W'(ld_addr));
  assign wr_ext = AW'(ld_addr);

  // Window element addressing.
  always_comb begin
    if ({1'b0, x} + 1'b1 == {1'b0, w}) begin
      x1 = '0;
      y1 = y + 1'b1;
    end else begin
      x1 = x + 1'b1;
      y1 = y;
    end
    case (k)
      2'd0: begin
        addr_k = pos;
        inner_k = is_inner(x, y, w, h);
      end
      2'd1: begin
        addr_k = pos + 1'b1;
        inner_k = is_inner(x1, y1, w, h);
      end
      2'd2: begin
        addr_k = pos + POS_W'(w);
        inner_k = is_inner(x, y + 1'b1, w, h);
      end
      default: begin
        addr_k = pos + POS_W'(w) + 1'b1;
        inner_k = is_inner(x1, y1 + 1'b1, w, h);
      end
    endcase
  end

  assign pos_end = (pos >= POS_W'(end_pos));
  assign raw = beyond ? 8'd0 : rdata;
  assign inv = ~raw;
  assign prod = {inv, 8'h00} - {8'h00, inv};
  assign hit = (win[0] >= THRESHOLD) || (win[1] >= THRESHOLD) ||
               (win[2] >= THRESHOLD) || (win[3] >= THRESHOLD);
  assign xs = (32'(x) * 32'd2 + 32'd1) * 32'd255 + 32'(win[1]) + 32'(win[3])
              - 32'(win[0]) - 32'(win[2]);
  assign ys = (32'(y) * 32'd2 + 32'd1) * 32'd255 + 32'(win[2]) + 32'(win[3])
              - 32'(win[0]) - 32'(win[1]);
  assign dk = 32'd1020 - 32'(win[0]) - 32'(win[1]) - 32'(win[2]) - 32'(win[3]);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = pos;
    if (state == S_SCAN && !pos_end && is_inner(x, y, w, h)) begin
      rd_en = 1'b1;
    end else if (state == S_RD) begin
      rd_addr = addr_k;
      rd_en = in_store(addr_k);
    end
  end
  assign rd_ext = AW'(rd_addr);

  assign cmd_pop = load_go || ((state == S_OUT) && (!res_valid || res_pop));

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_ext[SA-1:0]] <= cmd.pixel;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= store[rd_ext[SA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wa <= '0;
      maxv <= '0;
      wsync <= 1'b1;
      wcol <= '0;
      wrow <= '0;
      pos <= POS_W'(RESET_POS);
      res_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && res_pop) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (load_go) begin
            maxv <= (is_inner(ld_col, ld_row, w, h) && ld_inv > ld_max) ? ld_inv : ld_max;
            wa <= ld_addr + 1'b1;
            if (ld_addr == 18'h3FFFF) begin
              wcol <= '0;
              wrow <= '0;
            end else if ({1'b0, ld_col} + 1'b1 == {1'b0, w}) begin
              wcol <= '0;
              wrow <= ld_row + 1'b1;
            end else begin
              wcol <= ld_col + 1'b1;
              wrow <= ld_row;
            end
            wsync <= 1'b1;
            if (cmd.start) pos <= POS_W'(MARGIN * 32'(w) + MARGIN);
          end else if (cmd_valid && cmd.fetch) begin
            // The result register is written during the fetch, so a fetch
            // starts only once the previous result has been taken.
            if (!res_valid) begin
              div_start <= 1'b1;
              div_a <= pos;
              div_b <= {1'b0, w};
              state <= S_SDIV;
            end
          end else if (cmd_valid) begin
            div_start <= 1'b1;
            div_a <= POS_W'(wa);
            div_b <= {1'b0, w};
            state <= S_WDIV;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            wcol <= div_rem[DIM_W-1:0];
            wrow <= div_quot[ROW_W-1:0];
            wsync <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            x <= div_rem[DIM_W-1:0];
            y <= div_quot[ROW_W-1:0];
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pos_end) begin
            pos <= POS_W'(end_pos);
            res <= '0;
            state <= S_OUT;
          end else if (is_inner(x, y, w, h)) begin
            state <= S_CHK;
          end else begin
            pos <= pos + 1'b1;
            x <= x1;
            y <= y1;
          end
        end
        S_CHK: begin
          if (rdata == FULL) begin
            pos <= pos + 1'b1;
            x <= x1;
            y <= y1;
            state <= S_SCAN;
          end else begin
            k <= 2'd0;
            state <= S_RD;
          end
        end
        S_RD: begin
          beyond <= !in_store(addr_k);
          inner_kr <= inner_k;
          state <= S_VAL;
        end
        S_VAL: begin
          if (inner_kr && inv != 8'd0 && inv < maxv) begin
            div_start <= 1'b1;
            div_a <= POS_W'(prod);
            div_b <= (DIM_W+1)'(maxv);
            state <= S_RDIV;
          end else begin
            if (!inner_kr) win[k] <= raw;
            else if (inv == 8'd0) win[k] <= 8'd0;
            else win[k] <= FULL;
            if (k == 2'd3) state <= S_TEST;
            else begin
              k <= k + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_RDIV: begin
          if (div_done) begin
            win[k] <= div_quot[7:0];
            if (k == 2'd3) state <= S_TEST;
            else begin
              k <= k + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_TEST: begin
          pos <= pos + 1'b1;
          x <= x1;
          y <= y1;
          if (hit) begin
            res.found <= 1'b1;
            res.x_num <= xs[OUT_W-1:0];
            res.y_num <= ys[OUT_W-1:0];
            res.dark_x4 <= dk[9:0];
            res.pixel_index <= pos[OUT_W-1:0];
            state <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_OUT: begin
          if (!res_valid || res_pop) begin
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) wsync <= 1'b0;
    end
  end

endmodule

// File: bench/tb_invert_normalize_subpixel_points.sv
`timescale 1ns / 1ps

module tb_invert_normalize_subpixel_points;
  import insp_pkg::*;

  localparam int MARGIN = DEF_MARGIN;
  localparam int MIN_DIM = 2 * MARGIN + 2;
  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 400;

  // Pixel content styles for a loaded frame.
  localparam int STYLE_UNIFORM = 0;
  localparam int STYLE_SPOTS = 1;
  localparam int STYLE_WHITE = 2;
  localparam int STYLE_NARROW = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  insp_in_t request = '0;
  logic empty;
  logic pop = 1'b0;
  insp_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  invert_normalize_subpixel_points dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and points the block still owes us.
  insp_in_t pending_requests[$];
  insp_out_t expected_points[$];
  int errors = 0;
  // When calm is set neither side inserts idle cycles any more.
  bit calm = 1'b0;
  // Asks the result side for one long hold-off so the block backs up.
  bit hold_req = 1'b0;

  // ---------------------------------------------------------------------
  // Detector model: frame store, write pointer, running maximum of the
  // inverted inner pixels, scan pointer, and the two frame size registers.
  // ---------------------------------------------------------------------
  logic [7:0] frame_mem [STORE_DEPTH];
  logic [17:0] load_addr = '0;
  int unsigned darkest_inv = 0;
  int unsigned scan_at = MARGIN * DEF_MAX_WIDTH + MARGIN;
  logic [DIM_W-1:0] width_reg = DIM_W'(RESET_DIM);
  logic [DIM_W-1:0] height_reg = DIM_W'(RESET_DIM);

  // Register values outside the supported range are clamped by the block.
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
    if (v < MIN_DIM) v = MIN_DIM;
    if (v > mx) v = mx;
    return v;
  endfunction

  function automatic bit in_core(int unsigned a, int unsigned w, int unsigned h);
    int unsigned x, y;
    x = a % w;
    y = a / w;
    return x >= MARGIN && x + MARGIN < w && y >= MARGIN && y + MARGIN < h;
  endfunction

  function automatic int unsigned stored(int unsigned a);
    return a < STORE_DEPTH ? frame_mem[a] : 0;
  endfunction

  // Inner pixels contribute their stretched inverse, border pixels their raw
  // value. An inverse at or above the maximum saturates to full scale.
  function automatic int unsigned window_level(int unsigned a, int unsigned w,
                                               int unsigned h);
    int unsigned v;
    if (!in_core(a, w, h)) return stored(a);
    v = 255 - stored(a);
    if (v == 0) return 0;
    if (v >= darkest_inv) return 255;
    return (v * 255) / darkest_inv;
  endfunction

  task automatic model_load(logic [7:0] p, logic start);
    int unsigned w, h;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (start) begin
      load_addr = '0;
      darkest_inv = 0;
      scan_at = MARGIN * w + MARGIN;
    end
    if (load_addr < STORE_DEPTH) frame_mem[load_addr] = p;
    if (in_core(load_addr, w, h) && 255 - p > darkest_inv) darkest_inv = 255 - p;
    load_addr = load_addr + 1'b1;
  endtask

  // Walks the scan pointer to the next dark inner pixel whose 2x2 window has a
  // bright enough level, and forms its centroid and darkness.
  function automatic insp_out_t next_dark_point();
    int unsigned w, h, last, pos, a, b, c, d, x, y;
    insp_out_t pt;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    last = w * h;
    pt = '0;
    while (scan_at < last) begin
      pos = scan_at;
      scan_at++;
      if (!in_core(pos, w, h) || stored(pos) == 255) continue;
      a = window_level(pos, w, h);
      b = window_level(pos + 1, w, h);
      c = window_level(pos + w, w, h);
      d = window_level(pos + w + 1, w, h);
      if (a < THRESHOLD && b < THRESHOLD && c < THRESHOLD && d < THRESHOLD) continue;
      x = pos % w;
      y = pos / w;
      pt.found = 1'b1;
      pt.x_num = OUT_W'((2 * x + 1) * 255 + b + d - a - c);
      pt.y_num = OUT_W'((2 * y + 1) * 255 + c + d - a - b);
      pt.dark_x4 = 10'(1020 - (a + b + c + d));
      pt.pixel_index = OUT_W'(pos);
      return pt;
    end
    // Exhausted: the pointer parks at the end of the frame.
    if (scan_at > last) scan_at = last;
    return pt;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver. The model is advanced at the edge where a request is
  // taken, so the expected points stay in the order the block sees them.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    int gap_left;
    logic next_push;
    insp_in_t next_req;
    bit took;
    if (rst) begin
      gap_left = 0;
      push <= 1'b0;
    end else begin
      took = push && !full;
      next_push = 1'b0;
      next_req = request;
      if (took) begin
        if (request.command == CMD_FETCH) expected_points.push_back(next_dark_point());
        else model_load(request.pixel, request.frame_start);
        void'(pending_requests.pop_front());
      end
      if (push && !took) begin
        next_push = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_requests.size() > 0) begin
        if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 3);
        end else begin
          next_push = 1'b1;
          next_req = pending_requests[0];
        end
      end
      push <= next_push;
      request <= next_req;
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor. Each popped point is checked against the oldest one the
  // model produced. The hold-off is counted here, in the monitor's own loop.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : point_monitor
    int stall_left;
    int hold_left;
    bit hold_done;
    insp_out_t want;
    logic next_pop;
    if (rst) begin
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected point, got %p", $time, result);
        end else begin
          want = expected_points.pop_front();
          if (result.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0d got %0d", $time, want.found, result.found);
          end
          if (result.x_num !== want.x_num) begin
            errors++;
            $display("%0t: x_num expected %0d got %0d", $time, want.x_num, result.x_num);
          end
          if (result.y_num !== want.y_num) begin
            errors++;
            $display("%0t: y_num expected %0d got %0d", $time, want.y_num, result.y_num);
          end
          if (result.dark_x4 !== want.dark_x4) begin
            errors++;
            $display("%0t: dark_x4 expected %0d got %0d", $time, want.dark_x4,
                     result.dark_x4);
          end
          if (result.pixel_index !== want.pixel_index) begin
            errors++;
            $display("%0t: pixel_index expected %0d got %0d", $time, want.pixel_index,
                     result.pixel_index);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      next_pop = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        next_pop = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_pop = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 3);
        next_pop = 1'b0;
      end
      pop <= next_pop;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin : watchdog
    int cycles;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_invert_normalize_subpixel_points: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Waits until every request is taken and every point returned, then gives
  // trailing loads time to retire before the block is treated as idle.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || push || expected_points.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  function automatic logic [7:0] pick_pixel(int style);
    case (style)
      STYLE_SPOTS: begin
        if ($urandom_range(0, 11) == 0) return $urandom_range(0, 60);
        return $urandom_range(200, 255);
      end
      STYLE_WHITE: return 8'd255;
      STYLE_NARROW: return $urandom_range(235, 255);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic insp_in_t load_req(logic [7:0] p, logic start);
    insp_in_t r;
    r.command = CMD_LOAD;
    r.pixel = p;
    r.frame_start = start;
    return r;
  endfunction

  // Fetch requests carry random junk in the fields the block ignores.
  function automatic insp_in_t fetch_req();
    insp_in_t r;
    r.command = CMD_FETCH;
    r.pixel = $urandom_range(0, 255);
    r.frame_start = $urandom_range(0, 1);
    return r;
  endfunction

  // Sets the frame size, streams a whole frame plus a few stray loads past its
  // end, then asks for a number of points. Returns the number of requests.
  task automatic run_frame(logic [DIM_W-1:0] w_val, logic [DIM_W-1:0] h_val,
                           int style, int fetches, int extra, output int queued);
    int unsigned pixels;
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
    @(negedge clk);
    pixels = clamp_dim(w_val, DEF_MAX_WIDTH) * clamp_dim(h_val, DEF_MAX_HEIGHT);
    for (int unsigned i = 0; i < pixels + extra; i++)
      pending_requests.push_back(load_req(pick_pixel(style), i == 0));
    for (int i = 0; i < fetches; i++) pending_requests.push_back(fetch_req());
    queued = pixels + extra + fetches;
  endtask

  initial begin : stimulus
    int n;
    int random_reqs;
    int unsigned w, h, inner;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame, written as zero so it clamps up; the extremes of the
    // pixel range sit in the four inner pixels. Fetch past the last point so
    // the exhausted answer repeats.
    wait_idle();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    @(negedge clk);
    for (int i = 0; i < MIN_DIM * MIN_DIM; i++) begin
      if (i == MARGIN * MIN_DIM + MARGIN) pending_requests.push_back(load_req(8'd0, 1'b0));
      else if (i == MARGIN * MIN_DIM + MARGIN + 1)
        pending_requests.push_back(load_req(8'd255, 1'b0));
      else pending_requests.push_back(load_req(pick_pixel(STYLE_UNIFORM), i == 0));
    end
    for (int i = 0; i < 7; i++) pending_requests.push_back(fetch_req());

    // A frame abandoned early, then reloaded from its first pixel.
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 10'd24);
    write_reg(REG_FRAME_HEIGHT, 10'd22);
    @(negedge clk);
    for (int i = 0; i < 40; i++)
      pending_requests.push_back(load_req(pick_pixel(STYLE_UNIFORM), i == 0));
    for (int i = 0; i < 24 * 22; i++)
      pending_requests.push_back(load_req(pick_pixel(STYLE_SPOTS), i == 0));
    for (int i = 0; i < 8; i++) pending_requests.push_back(fetch_req());

    // Back-pressure: a long run of fetches while the result side holds off.
    run_frame(MIN_DIM, MIN_DIM, STYLE_UNIFORM, 45, 0, n);
    while (pending_requests.size() > 45) @(negedge clk);
    hold_req = 1'b1;

    // Random frames of small sizes; this last stretch runs without idling.
    wait_idle();
    calm = 1'b1;
    random_reqs = 0;
    while (random_reqs < 400) begin
      w = $urandom_range(MIN_DIM, 30);
      h = $urandom_range(MIN_DIM, 26);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(0, MIN_DIM - 1);
      inner = (clamp_dim(w, DEF_MAX_WIDTH) - 2 * MARGIN) *
              (clamp_dim(h, DEF_MAX_HEIGHT) - 2 * MARGIN);
      run_frame(DIM_W'(w), DIM_W'(h), $urandom_range(STYLE_UNIFORM, STYLE_NARROW),
                $urandom_range(1, inner + 3), $urandom_range(0, 3), n);
      random_reqs += n;
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_invert_normalize_subpixel_points: done, clean");
    end else begin
      $display("tb_invert_normalize_subpixel_points: done, errors");
    end
    $finish;
  end

endmodule
